@@ rtl/utf8v_pkg.sv @@
// Shared constants for the UTF-8 structure validator.
package utf8v_pkg;

    // Default width of the byte position counter
    localparam int unsigned POS_BITS_DEFAULT = 32;

    // Width of the reported end position
    localparam int unsigned END_POS_BITS = 32;

    // Byte classification masks and patterns
    localparam logic [7:0] ONE_BYTE_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_MASK   = 8'hE0;
    localparam logic [7:0] LEAD2_PAT    = 8'hC0;
    localparam logic [7:0] LEAD3_MASK   = 8'hF0;
    localparam logic [7:0] LEAD3_PAT    = 8'hE0;
    localparam logic [7:0] LEAD4_MASK   = 8'hF8;
    localparam logic [7:0] LEAD4_PAT    = 8'hF0;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_PAT     = 8'h80;

    // Continuation bytes still owed by an open sequence
    typedef logic [1:0] pend_t;

    localparam pend_t PEND_NONE = 2'd0;
    localparam pend_t PEND_ONE  = 2'd1;
    localparam pend_t PEND_TWO  = 2'd2;
    localparam pend_t PEND_THR  = 2'd3;

endpackage

@@ rtl/utf8_structure_validator_top.sv @@
// UTF-8 structure validator: byte-serial checker with a registered result stage.
// Throughput: one byte per clock, but a last byte stalls while a result waits untaken.
// The result appears on m_valid in the cycle after the last byte is accepted.
// Non-last bytes are taken even while a finished result waits on the output register.
// Reset (aresetn low, synchronous) clears the counter, sequence and error state
// and empties the output register; state also returns to reset after each last byte.
module utf8_structure_validator_top #(
    parameter int unsigned POS_BITS = utf8v_pkg::POS_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_last_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_valid_res,
    output logic [utf8v_pkg::END_POS_BITS-1:0] m_end_pos
);
    import utf8v_pkg::*;

    typedef logic [POS_BITS-1:0] pos_t;

    // Sequence and position state
    pend_t pend_reg, pend_next;
    pos_t  lead_reg, lead_next;
    pos_t  cnt_reg, cnt_next;
    logic  err_reg, err_next;
    pos_t  err_pos_reg, err_pos_next;

    // Output register
    logic                    m_valid_reg, m_valid_next;
    logic                    res_ok_reg, res_ok_next;
    logic [END_POS_BITS-1:0] res_pos_reg, res_pos_next;

    logic       accept;
    logic       out_take;
    pos_t       cnt_inc;
    pend_t      pend_upd;
    pos_t       lead_upd;
    logic       err_upd;
    pos_t       err_pos_upd;
    pos_t       end_val;
    logic       end_ok;
    logic [63:0] end_wide;

    // Non-last items never need the output slot
    assign s_ready  = !m_valid_reg || m_ready || !s_last_byte;
    assign accept   = s_valid && s_ready;
    assign out_take = m_valid_reg && m_ready;

    // Saturating position counter
    assign cnt_inc = (&cnt_reg) ? cnt_reg : cnt_reg + pos_t'(1);

    // Classify the incoming byte against the current sequence state
    always_comb begin
        pend_upd    = pend_reg;
        lead_upd    = lead_reg;
        err_upd     = err_reg;
        err_pos_upd = err_pos_reg;
        if (pend_reg != PEND_NONE) begin
            if (!err_reg && ((s_data_byte & CONT_MASK) != CONT_PAT)) begin
                err_upd     = 1'b1;
                err_pos_upd = cnt_reg;
            end
            pend_upd = pend_reg - PEND_ONE;
        end else if (!err_reg) begin
            if (s_data_byte <= ONE_BYTE_MAX) begin
                pend_upd = PEND_NONE;
            end else if ((s_data_byte & LEAD2_MASK) == LEAD2_PAT) begin
                pend_upd = PEND_ONE;
                lead_upd = cnt_reg;
            end else if ((s_data_byte & LEAD3_MASK) == LEAD3_PAT) begin
                pend_upd = PEND_TWO;
                lead_upd = cnt_reg;
            end else if ((s_data_byte & LEAD4_MASK) == LEAD4_PAT) begin
                pend_upd = PEND_THR;
                lead_upd = cnt_reg;
            end else begin
                err_upd     = 1'b1;
                err_pos_upd = cnt_reg;
            end
        end
    end

    // Pick the reported position: cut-off sequence, then first error, then length
    always_comb begin
        if (pend_upd != PEND_NONE) begin
            end_ok  = 1'b0;
            end_val = lead_upd;
        end else if (err_upd) begin
            end_ok  = 1'b0;
            end_val = err_pos_upd;
        end else begin
            end_ok  = 1'b1;
            end_val = cnt_inc;
        end
    end

    assign end_wide = 64'(end_val);

    // Advance state on accept; drop back to reset after the last byte
    always_comb begin
        pend_next    = pend_reg;
        lead_next    = lead_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        err_pos_next = err_pos_reg;
        if (accept) begin
            if (s_last_byte) begin
                pend_next    = PEND_NONE;
                lead_next    = '0;
                cnt_next     = '0;
                err_next     = 1'b0;
                err_pos_next = '0;
            end else begin
                pend_next    = pend_upd;
                lead_next    = lead_upd;
                cnt_next     = cnt_inc;
                err_next     = err_upd;
                err_pos_next = err_pos_upd;
            end
        end
    end

    // Load the output register on a last byte, hold until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        res_ok_next  = res_ok_reg;
        res_pos_next = res_pos_reg;
        if (out_take) begin
            m_valid_next = 1'b0;
        end
        if (accept && s_last_byte) begin
            m_valid_next = 1'b1;
            res_ok_next  = end_ok;
            res_pos_next = end_wide[END_POS_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= PEND_NONE;
            lead_reg    <= '0;
            cnt_reg     <= '0;
            err_reg     <= 1'b0;
            err_pos_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            lead_reg    <= lead_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            err_pos_reg <= err_pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge aclk) begin
        res_ok_reg  <= res_ok_next;
        res_pos_reg <= res_pos_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_valid_res = res_ok_reg;
    assign m_end_pos   = res_pos_reg;

    // A last byte returns the buffer state to reset
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_byte) |=> (cnt_reg == '0 && pend_reg == PEND_NONE && !err_reg))
        else $error("state not cleared after last byte");

    // A last byte always loads a result
    a_last_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_byte) |=> m_valid_reg)
        else $error("no result after last byte");

    // Non-last bytes advance the counter by one until it saturates
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_last_byte && !(&cnt_reg)) |=> (cnt_reg == $past(cnt_reg) + pos_t'(1)))
        else $error("byte counter did not advance");

    // An open sequence starts before the current position, unless the counter saturated
    a_lead_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != PEND_NONE) |-> (lead_reg < cnt_reg || (&cnt_reg)))
        else $error("lead position beyond byte counter");

    // A recorded error lies behind the current position, unless the counter saturated
    a_err_order: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> (err_pos_reg < cnt_reg || (&cnt_reg)))
        else $error("error position beyond byte counter");

endmodule

@@ tb/tb_utf8_structure_validator_top.sv @@
// Self-checking testbench for the byte-serial UTF-8 structure validator.
module tb_utf8_structure_validator_top;

    import utf8v_pkg::*;

    localparam int unsigned POS_BITS = POS_BITS_DEFAULT;

    typedef logic [POS_BITS-1:0] pos_t;

    localparam pos_t POS_MAX = '1;

    // Verdict that one buffer should produce
    typedef struct packed {
        logic                    ok;
        logic [END_POS_BITS-1:0] pos;
    } verdict_t;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_data_byte = 8'h00;
    logic                    s_last_byte = 1'b0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic                    m_valid_res;
    logic [END_POS_BITS-1:0] m_end_pos;

    // Predicted buffer state
    pend_t       pend_cnt = PEND_NONE;
    pos_t        lead_at  = '0;
    pos_t        next_idx = '0;
    logic        err_flag = 1'b0;
    pos_t        err_at   = '0;

    verdict_t    verdict_q[$];
    int unsigned n_bad       = 0;
    int unsigned burst_left  = 0;
    int unsigned rx_left     = 0;
    int unsigned rx_mode     = 0;

    utf8_structure_validator_top #(
        .POS_BITS(POS_BITS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res),
        .m_end_pos   (m_end_pos)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the predicted state by one accepted byte; queue a verdict on the last one
    function automatic void track_byte(input logic [7:0] b, input logic last);
        pos_t     idx;
        verdict_t v;
        idx = next_idx;
        if (pend_cnt != PEND_NONE) begin
            if (!err_flag && (b & CONT_MASK) != CONT_PAT) begin
                err_flag = 1'b1;
                err_at   = idx;
            end
            pend_cnt = pend_cnt - 2'd1;
        end else if (!err_flag && b > ONE_BYTE_MAX) begin
            if ((b & LEAD2_MASK) == LEAD2_PAT) begin
                pend_cnt = PEND_ONE;
                lead_at  = idx;
            end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
                pend_cnt = PEND_TWO;
                lead_at  = idx;
            end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
                pend_cnt = PEND_THR;
                lead_at  = idx;
            end else begin
                err_flag = 1'b1;
                err_at   = idx;
            end
        end
        next_idx = (idx == POS_MAX) ? idx : idx + pos_t'(1);
        if (last) begin
            // a cut-off sequence outranks any error inside it
            if (pend_cnt != PEND_NONE) begin
                v.ok  = 1'b0;
                v.pos = lead_at;
            end else if (err_flag) begin
                v.ok  = 1'b0;
                v.pos = err_at;
            end else begin
                v.ok  = 1'b1;
                v.pos = next_idx;
            end
            verdict_q.push_back(v);
            pend_cnt = PEND_NONE;
            lead_at  = '0;
            next_idx = '0;
            err_flag = 1'b0;
            err_at   = '0;
        end
    endfunction

    // Present one item, idling between random bursts, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid     <= 1'b0;
                s_data_byte <= 8'($urandom);
                s_last_byte <= 1'($urandom);
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left  = burst_left - 1;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        track_byte(b, last);
    endtask

    // Hold the sender until every queued verdict has come back
    task automatic await_verdicts();
        s_valid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_ascii_bounds();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_lead_bounds();
        send_byte(8'hDF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Lone continuation, then a bad lead followed by bytes that must be ignored
    task automatic test_bad_start();
        send_byte(8'h80, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Bad continuation; the byte still claimed by the sequence is not a new start
    task automatic test_bad_continuation();
        send_byte(8'hE0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    // Buffers that end inside a sequence, one of them also holding a bad continuation
    task automatic test_cut_off();
        send_byte(8'hC2, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Mostly well-formed text of random length, with noise, corruption and truncation
    task automatic test_random_buffers();
        logic [7:0]  buf_q[$];
        logic [7:0]  r;
        int unsigned sent;
        int unsigned units;
        int unsigned seq_len;
        int unsigned k;
        sent = 0;
        while (sent < 750) begin
            buf_q.delete();
            units = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 6);
            repeat (units) begin
                k = $urandom_range(0, 9);
                r = 8'($urandom);
                if (k < 4) begin
                    buf_q.push_back({1'b0, r[6:0]});
                end else if (k < 8) begin
                    seq_len = $urandom_range(2, 4);
                    case (seq_len)
                        2: buf_q.push_back({3'b110, r[4:0]});
                        3: buf_q.push_back({4'b1110, r[3:0]});
                        default: buf_q.push_back({5'b11110, r[2:0]});
                    endcase
                    repeat (seq_len - 1) begin
                        r = 8'($urandom);
                        // corrupt a continuation now and then
                        if ($urandom_range(0, 11) == 0) begin
                            buf_q.push_back(r);
                        end else begin
                            buf_q.push_back({2'b10, r[5:0]});
                        end
                    end
                end else begin
                    buf_q.push_back(r);
                end
            end
            // drop the tail, often mid-sequence
            if (buf_q.size() > 1 && $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    if (buf_q.size() > 1) begin
                        buf_q.delete(buf_q.size() - 1);
                    end
                end
            end
            foreach (buf_q[i]) begin
                send_byte(buf_q[i], i == buf_q.size() - 1);
            end
            sent = sent + buf_q.size();
            if ($urandom_range(0, 24) == 0) begin
                await_verdicts();
            end
        end
    endtask

    // Stall the result channel on its own changing pattern
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_left <= $urandom_range(20, 200);
            rx_mode <= $urandom_range(0, 2);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each accepted result with the oldest queued verdict
    always @(posedge aclk) begin : check_results
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                n_bad = n_bad + 1;
                if (n_bad <= 10) begin
                    $display("unexpected result: ok=%0b pos=%0d", m_valid_res, m_end_pos);
                end
            end else begin
                want = verdict_q.pop_front();
                if (m_valid_res !== want.ok || m_end_pos !== want.pos) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10) begin
                        $display("mismatch: expected ok=%0b pos=%0d, got ok=%0b pos=%0d",
                                 want.ok, want.pos, m_valid_res, m_end_pos);
                    end
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_ascii_bounds();
        test_lead_bounds();
        await_verdicts();
        test_bad_start();
        test_bad_continuation();
        await_verdicts();
        test_cut_off();
        await_verdicts();
        test_random_buffers();
        await_verdicts();
        repeat (10) @(posedge aclk);
        if (n_bad == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/utf8v_pkg.sv
rtl/utf8_structure_validator_top.sv
tb/tb_utf8_structure_validator_top.sv
